/* sv/ccio_pkg.sv */
// Shared types and constants of the coin and credit I/O block.
// No dependencies; imported by ccio_credit, the top level and the testbench.
`timescale 1ns / 1ps
`default_nettype none
package ccio_pkg;

   localparam logic [5:0] MODE_ENTRY = 6'd24;
   localparam logic [7:0] MODE_TEST  = 8'd7;
   localparam logic [7:0] MODE_PORTS = 8'd1;
   localparam logic [6:0] CREDIT_MAX = 7'd99;

   typedef struct packed {
      logic [1:0] need;
      logic [2:0] pay;
   } ccio_coinage_type;

   localparam ccio_coinage_type COIN_A_TABLE [8] = '{
      '{2'd1, 3'd1}, '{2'd2, 3'd1}, '{2'd1, 3'd3}, '{2'd3, 3'd1},
      '{2'd1, 3'd2}, '{2'd2, 3'd3}, '{2'd1, 3'd6}, '{2'd3, 3'd2}
   };

   localparam ccio_coinage_type COIN_B_TABLE [4] = '{
      '{2'd1, 3'd1}, '{2'd1, 3'd7}, '{2'd1, 3'd5}, '{2'd2, 3'd1}
   };

   typedef struct packed {
      logic coin_read;
      logic start_read;
   } ccio_credit_cmd_type;

   typedef struct packed {
      logic [3:0] coin_bits;
      logic [3:0] start_bits;
      logic [3:0] tens;
      logic [3:0] units;
   } ccio_credit_stat_type;

endpackage
`default_nettype wire

/* sv/ccio_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module ccio_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

/* sv/ccio_credit.sv */
// Coin counting, start-button credit taking and BCD credit display.
// Depends on ccio_pkg for coinage tables and command/status structs.
`timescale 1ns / 1ps
`default_nettype none
module ccio_credit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire ccio_pkg::ccio_credit_cmd_type cmd,
   input  wire logic [7:0]                    port0,
   input  wire logic [7:0]                    port1,
   input  wire logic [7:0]                    port3,
   output ccio_pkg::ccio_credit_stat_type     stat
);
   import ccio_pkg::*;

   logic [6:0] credit_ff, credit_in;
   logic [1:0] coin_a_ff, coin_a_in;
   logic [1:0] coin_b_ff, coin_b_in;
   logic [3:0] last_coin_ff, last_coin_in;
   logic [3:0] last_start_ff, last_start_in;
   logic [3:0] start_bits;
   logic [14:0] tens_prod;
   logic [6:0]  units_full;

   function automatic logic [6:0] sat_add(input logic [6:0] c, input logic [2:0] pay);
      logic [7:0] s;
      s = {1'b0, c} + {5'd0, pay};
      return (s > {1'b0, CREDIT_MAX}) ? CREDIT_MAX : s[6:0];
   endfunction

   always_comb begin
      ccio_coinage_type ent_a;
      ccio_coinage_type ent_b;
      logic [2:0] cnt;
      logic [3:0] v;
      ent_a = COIN_A_TABLE[port1[7:5]];
      ent_b = COIN_B_TABLE[port0[4:3]];
      cnt           = 3'd0;
      credit_in     = credit_ff;
      coin_a_in     = coin_a_ff;
      coin_b_in     = coin_b_ff;
      last_coin_in  = last_coin_ff;
      last_start_in = last_start_ff;
      v = port3[7:4];
      if (cmd.coin_read) begin
         if (port3[0] && !last_coin_ff[0]) begin
            cnt = {1'b0, coin_a_ff} + 3'd1;
            if (cnt >= {1'b0, ent_a.need}) begin
               credit_in = sat_add(credit_in, ent_a.pay);
               coin_a_in = 2'd0;
            end else begin
               coin_a_in = cnt[1:0];
            end
         end
         if (port3[1] && !last_coin_ff[1]) begin
            cnt = {1'b0, coin_b_ff} + 3'd1;
            if (cnt >= {1'b0, ent_b.need}) begin
               credit_in = sat_add(credit_in, ent_b.pay);
               coin_b_in = 2'd0;
            end else begin
               coin_b_in = cnt[1:0];
            end
         end
         last_coin_in = port3[3:0];
      end
      if (v[0] && !last_start_ff[0]) begin
         if (credit_in >= 7'd1) begin
            credit_in = cmd.start_read ? credit_in - 7'd1 : credit_in;
         end else begin
            v[0] = 1'b0;
         end
      end
      if (v[1] && !last_start_ff[1]) begin
         if (credit_in >= 7'd2) begin
            credit_in = cmd.start_read ? credit_in - 7'd2 : credit_in;
         end else begin
            v[1] = 1'b0;
         end
      end
      if (cmd.start_read) begin
         last_start_in = v;
      end else begin
         credit_in = cmd.coin_read ? credit_in : credit_ff;
      end
      start_bits = v;
   end

   assign tens_prod  = 15'(credit_ff) * 15'd205;
   assign units_full = credit_ff - (7'(tens_prod[14:11]) * 7'd10);
   assign stat       = '{coin_bits:  port3[3:0],
                         start_bits: start_bits,
                         tens:       tens_prod[14:11],
                         units:      units_full[3:0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff     <= '0;
         coin_a_ff     <= '0;
         coin_b_ff     <= '0;
         last_coin_ff  <= '0;
         last_start_ff <= '0;
      end else begin
         credit_ff     <= credit_in;
         coin_a_ff     <= coin_a_in;
         coin_b_ff     <= coin_b_in;
         last_coin_ff  <= last_coin_in;
         last_start_ff <= last_start_in;
      end
   end

endmodule
`default_nettype wire

/* sv/coin_credit_custom_io.sv */
// Top level of the coin and credit custom I/O block: bus decode, mode
// handling and result staging. Depends on ccio_pkg, ccio_ram, ccio_credit.
//
//   channel   direction   handshake              payload
//   req       in          req_valid/req_ready    req_type, req_offset, req_write_data,
//                                                req_port0..req_port5
//   rsp       out         rsp_valid/rsp_ready    rsp_read_data
//
// One word accepted per cycle while req_ready is high; the RAM read and the
// input stage load at the accepting edge, the result register when the input
// stage advances while the result register is empty or being taken.
// Reset clears the RAM valid bits, mode shadow and credit state at once;
// no clearing pass is needed.
// A stalled result holds; req_ready drops only when both stages are full.
`timescale 1ns / 1ps
`default_nettype none
module coin_credit_custom_io #(
   parameter int IO_RAM_DEPTH = 64
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic       req_type,
   input  wire logic [5:0] req_offset,
   input  wire logic [7:0] req_write_data,
   input  wire logic [7:0] req_port0,
   input  wire logic [7:0] req_port1,
   input  wire logic [7:0] req_port2,
   input  wire logic [7:0] req_port3,
   input  wire logic [7:0] req_port4,
   input  wire logic [7:0] req_port5,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_read_data
);
   import ccio_pkg::*;

   localparam int AW = $clog2(IO_RAM_DEPTH);

   localparam logic [5:0] OFS_COIN   = 6'd0;
   localparam logic [5:0] OFS_START  = 6'd1;
   localparam logic [5:0] OFS_TENS   = 6'd2;
   localparam logic [5:0] OFS_UNITS  = 6'd3;
   localparam logic [5:0] OFS_P4_HI  = 6'd4;
   localparam logic [5:0] OFS_P5_HI  = 6'd6;
   localparam logic [5:0] OFS_P1_HI  = 6'd16;
   localparam logic [5:0] OFS_P0_LO  = 6'd17;
   localparam logic [5:0] OFS_P0_HI  = 6'd18;
   localparam logic [5:0] OFS_P1_LO  = 6'd19;
   localparam logic [5:0] OFS_P4_LO  = 6'd34;
   localparam logic [5:0] OFS_P5_LO  = 6'd36;
   localparam logic [5:0] OFS_P2_LO  = 6'd39;
   localparam logic [7:0] TEST_AT_2  = 8'd15;
   localparam logic [7:0] TEST_AT_6  = 8'd12;
   localparam logic [7:0] TEST_AT_18 = 8'd14;
   localparam logic [7:0] TEST_AT_39 = 8'd6;

   logic                    accept, in_range, wr_en, rd_en, hit;
   logic [AW-1:0]           ram_addr;
   logic [7:0]              ram_q;
   logic [IO_RAM_DEPTH-1:0] valid_ff, valid_in;
   logic [7:0]              mode_ff, mode_in;
   logic                    s1_valid_ff, s1_valid_in;
   logic                    s1_use_ram_ff, s1_use_ram_in;
   logic [7:0]              s1_special_ff, s1_special_in;
   logic                    s1_advance;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [7:0]              rsp_data_ff, rsp_data_in;
   ccio_credit_cmd_type     cmd;
   ccio_credit_stat_type    stat;

   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign accept     = req_valid && req_ready;
   assign in_range   = 32'(req_offset) < IO_RAM_DEPTH;
   assign ram_addr   = AW'(req_offset);
   assign wr_en      = accept && !req_type && in_range;
   assign rd_en      = accept && req_type;
   assign hit        = in_range && valid_ff[ram_addr];

   ccio_ram #(
      .WIDTH(8),
      .DEPTH(IO_RAM_DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(ram_addr),
      .wr_data(req_write_data),
      .rd_en  (rd_en),
      .rd_addr(ram_addr),
      .rd_data(ram_q)
   );

   assign cmd = '{coin_read:  rd_en && (mode_ff == MODE_PORTS) && (req_offset == OFS_COIN),
                  start_read: rd_en && (mode_ff == MODE_PORTS) && (req_offset == OFS_START)};

   ccio_credit u_credit (
      .clock(clock),
      .reset(reset),
      .cmd  (cmd),
      .port0(req_port0),
      .port1(req_port1),
      .port3(req_port3),
      .stat (stat)
   );

   always_comb begin
      valid_in = valid_ff;
      mode_in  = mode_ff;
      if (wr_en) begin
         valid_in[ram_addr] = 1'b1;
         if (req_offset == MODE_ENTRY) begin
            mode_in = req_write_data;
         end
      end
   end

   always_comb begin
      s1_use_ram_in = 1'b0;
      s1_special_in = 8'd0;
      if (req_type) begin
         if (mode_ff == MODE_TEST) begin
            case (req_offset)
               OFS_TENS:  s1_special_in = TEST_AT_2;
               OFS_P5_HI: s1_special_in = TEST_AT_6;
               OFS_P0_HI: s1_special_in = TEST_AT_18;
               OFS_P2_LO: s1_special_in = TEST_AT_39;
               default:   s1_use_ram_in = hit;
            endcase
         end else if (mode_ff == MODE_PORTS) begin
            case (req_offset)
               OFS_COIN:  s1_special_in = {4'd0, stat.coin_bits};
               OFS_START: s1_special_in = {4'd0, stat.start_bits};
               OFS_TENS:  s1_special_in = {4'd0, stat.tens};
               OFS_UNITS: s1_special_in = {4'd0, stat.units};
               OFS_P4_HI: s1_special_in = {4'd0, req_port4[7:4]};
               OFS_P5_HI: s1_special_in = {4'd0, req_port5[7:4]};
               OFS_P1_HI: s1_special_in = {4'd0, req_port1[7:4]};
               OFS_P0_LO: s1_special_in = {4'd0, req_port0[3:0]};
               OFS_P0_HI: s1_special_in = {4'd0, req_port0[7:4]};
               OFS_P1_LO: s1_special_in = {4'd0, req_port1[3:0]};
               OFS_P4_LO: s1_special_in = {4'd0, req_port4[3:0]};
               OFS_P5_LO: s1_special_in = {4'd0, req_port5[3:0]};
               OFS_P2_LO: s1_special_in = {4'd0, req_port2[3:0]};
               default:   s1_use_ram_in = hit;
            endcase
         end else begin
            s1_use_ram_in = hit;
         end
      end
   end

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
      if (s1_advance) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = s1_use_ram_ff ? ram_q : s1_special_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         mode_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         mode_ff      <= mode_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_use_ram_ff <= s1_use_ram_in;
         s1_special_ff <= s1_special_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;

endmodule
`default_nettype wire

/* sv/ccio_checker.sv */
// Port-level checks of the coin and credit I/O block, bound to the top level.
// Depends on coin_credit_custom_io port names only.
`timescale 1ns / 1ps
`default_nettype none
module ccio_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_read_data
);

   a_reset_empties: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !rsp_valid) |-> ##2 rsp_valid)
      else $error("accepted word produced no result");

   a_ready_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("input stalled while result path free");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_read_data)))
      else $error("stalled result changed");

endmodule

bind coin_credit_custom_io ccio_checker u_ccio_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_read_data(rsp_read_data)
);
`default_nettype wire

/* sim/tb_top.sv */
// Testbench of coin_credit_custom_io: directed table then random bus words,
// each result checked against a local model of the I/O RAM and credit logic.
// Depends on ccio_pkg and the RTL of the block only.
`timescale 1ns / 1ps
module tb_top;
   import ccio_pkg::*;

   localparam logic ACC_WRITE = 1'b0;
   localparam logic ACC_READ  = 1'b1;

   localparam logic [5:0] OFS_COIN   = 6'd0;
   localparam logic [5:0] OFS_START  = 6'd1;
   localparam logic [5:0] OFS_TENS   = 6'd2;
   localparam logic [5:0] OFS_UNITS  = 6'd3;
   localparam logic [5:0] OFS_P4_HI  = 6'd4;
   localparam logic [5:0] OFS_P5_HI  = 6'd6;
   localparam logic [5:0] OFS_P1_HI  = 6'd16;
   localparam logic [5:0] OFS_P0_LO  = 6'd17;
   localparam logic [5:0] OFS_P0_HI  = 6'd18;
   localparam logic [5:0] OFS_P1_LO  = 6'd19;
   localparam logic [5:0] OFS_P4_LO  = 6'd34;
   localparam logic [5:0] OFS_P5_LO  = 6'd36;
   localparam logic [5:0] OFS_P2_LO  = 6'd39;
   localparam logic [5:0] OFS_TEST_0 = 6'd2;
   localparam logic [5:0] OFS_TEST_1 = 6'd6;
   localparam logic [5:0] OFS_TEST_2 = 6'd18;
   localparam logic [5:0] OFS_TEST_3 = 6'd39;
   localparam logic [5:0] OFS_TOP    = 6'd63;

   localparam logic [5:0] MAPPED [13] = '{
      OFS_COIN, OFS_START, OFS_TENS, OFS_UNITS, OFS_P4_HI, OFS_P5_HI, OFS_P1_HI,
      OFS_P0_LO, OFS_P0_HI, OFS_P1_LO, OFS_P4_LO, OFS_P5_LO, OFS_P2_LO
   };

   localparam int N_DIRECTED = 25;
   localparam int N_RANDOM   = 400;
   localparam int IDLE_LIMIT = 2000;

   typedef struct packed {
      logic       kind;
      logic [5:0] ofs;
      logic [7:0] wdata;
      logic [7:0] p0;
      logic [7:0] p1;
      logic [7:0] p2;
      logic [7:0] p3;
      logic [7:0] p4;
      logic [7:0] p5;
      logic       fixed;
      logic [7:0] want;
   } access_row_type;

   typedef struct packed {
      int         idx;
      logic [7:0] val;
   } due_byte_type;

   // kind, offset, data, port0..port5, fixed, fixed value
   localparam access_row_type DIRECTED [N_DIRECTED] = '{
      '{ACC_READ,  OFS_COIN,   8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00},
      '{ACC_WRITE, OFS_TOP,    8'hff, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00},
      '{ACC_READ,  OFS_TOP,    8'h00, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 1'b1, 8'hff},
      '{ACC_WRITE, MODE_ENTRY, MODE_TEST, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        1'b1, 8'h00},
      '{ACC_READ,  OFS_TEST_0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 8'd15},
      '{ACC_READ,  OFS_TEST_1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 8'd12},
      '{ACC_READ,  OFS_TEST_2, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 8'd14},
      '{ACC_READ,  OFS_TEST_3, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 8'd6},
      '{ACC_WRITE, MODE_ENTRY, MODE_PORTS, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        1'b1, 8'h00},
      '{ACC_READ,  OFS_START,  8'h00, 8'h00, 8'h00, 8'h00, 8'h30, 8'h00, 8'h00, 1'b1, 8'h00},
      '{ACC_READ,  OFS_COIN,   8'h00, 8'h18, 8'he0, 8'h00, 8'h03, 8'h00, 8'h00, 1'b1, 8'h03},
      '{ACC_READ,  OFS_COIN,   8'h00, 8'h18, 8'he0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00},
      '{ACC_READ,  OFS_COIN,   8'h00, 8'h08, 8'hc0, 8'h00, 8'h0f, 8'h00, 8'h00, 1'b1, 8'h0f},
      '{ACC_READ,  OFS_TENS,   8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00},
      '{ACC_READ,  OFS_UNITS,  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00},
      '{ACC_READ,  OFS_START,  8'h00, 8'h00, 8'h00, 8'h00, 8'hf0, 8'h00, 8'h00, 1'b0, 8'h00},
      '{ACC_READ,  OFS_P4_HI,  8'h00, 8'ha5, 8'h5a, 8'hc3, 8'h00, 8'h96, 8'h69, 1'b0, 8'h00},
      '{ACC_READ,  OFS_P5_HI,  8'h00, 8'ha5, 8'h5a, 8'hc3, 8'h00, 8'h96, 8'h69, 1'b0, 8'h00},
      '{ACC_READ,  OFS_P1_HI,  8'h00, 8'ha5, 8'h5a, 8'hc3, 8'h00, 8'h96, 8'h69, 1'b0, 8'h00},
      '{ACC_READ,  OFS_P0_LO,  8'h00, 8'ha5, 8'h5a, 8'hc3, 8'h00, 8'h96, 8'h69, 1'b0, 8'h00},
      '{ACC_READ,  OFS_P0_HI,  8'h00, 8'ha5, 8'h5a, 8'hc3, 8'h00, 8'h96, 8'h69, 1'b0, 8'h00},
      '{ACC_READ,  OFS_P1_LO,  8'h00, 8'ha5, 8'h5a, 8'hc3, 8'h00, 8'h96, 8'h69, 1'b0, 8'h00},
      '{ACC_READ,  OFS_P4_LO,  8'h00, 8'ha5, 8'h5a, 8'hc3, 8'h00, 8'h96, 8'h69, 1'b0, 8'h00},
      '{ACC_READ,  OFS_P5_LO,  8'h00, 8'ha5, 8'h5a, 8'hc3, 8'h00, 8'h96, 8'h69, 1'b0, 8'h00},
      '{ACC_READ,  OFS_P2_LO,  8'h00, 8'ha5, 8'h5a, 8'hc3, 8'h00, 8'h96, 8'h69, 1'b0, 8'h00}
   };

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic       req_type;
   logic [5:0] req_offset;
   logic [7:0] req_write_data;
   logic [7:0] req_port0;
   logic [7:0] req_port1;
   logic [7:0] req_port2;
   logic [7:0] req_port3;
   logic [7:0] req_port4;
   logic [7:0] req_port5;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [7:0] rsp_read_data;

   logic [7:0] io_ram_copy [64];
   logic [6:0] credits;
   logic [1:0] coin_a_cnt;
   logic [1:0] coin_b_cnt;
   logic [3:0] last_coin;
   logic [3:0] last_start;

   due_byte_type read_bytes_due [$];
   int           mismatches = 0;
   int           rsp_count = 0;
   int           idle_cycles = 0;
   bit           hold_off = 1'b0;

   coin_credit_custom_io DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_offset     (req_offset),
      .req_write_data (req_write_data),
      .req_port0      (req_port0),
      .req_port1      (req_port1),
      .req_port2      (req_port2),
      .req_port3      (req_port3),
      .req_port4      (req_port4),
      .req_port5      (req_port5),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_read_data  (rsp_read_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void add_credits(logic [2:0] pay);
      int sum;
      sum = int'(credits) + int'(pay);
      credits = (sum > int'(CREDIT_MAX)) ? CREDIT_MAX : 7'(sum);
   endfunction

   function automatic logic [1:0] coin_insert(logic [1:0] cnt, ccio_coinage_type c);
      logic [2:0] n;
      n = {1'b0, cnt} + 3'd1;
      if (n >= {1'b0, c.need}) begin
         add_credits(c.pay);
         n = 3'd0;
      end
      return n[1:0];
   endfunction

   function automatic logic [7:0] bus_access_result(access_row_type a);
      logic [7:0] r;
      logic [3:0] v;
      r = 8'h00;
      if (a.kind == ACC_WRITE) begin
         io_ram_copy[a.ofs] = a.wdata;
         return 8'h00;
      end
      if (io_ram_copy[MODE_ENTRY] == MODE_TEST) begin
         case (a.ofs)
            OFS_TEST_0: r = 8'd15;
            OFS_TEST_1: r = 8'd12;
            OFS_TEST_2: r = 8'd14;
            OFS_TEST_3: r = 8'd6;
            default: r = io_ram_copy[a.ofs];
         endcase
      end else if (io_ram_copy[MODE_ENTRY] == MODE_PORTS) begin
         case (a.ofs)
            OFS_COIN: begin
               v = a.p3[3:0];
               if (v[0] && !last_coin[0])
                  coin_a_cnt = coin_insert(coin_a_cnt, COIN_A_TABLE[a.p1[7:5]]);
               if (v[1] && !last_coin[1])
                  coin_b_cnt = coin_insert(coin_b_cnt, COIN_B_TABLE[a.p0[4:3]]);
               last_coin = v;
               r = {4'h0, v};
            end
            OFS_START: begin
               v = a.p3[7:4];
               if (v[0] && !last_start[0]) begin
                  if (credits >= 7'd1) credits = credits - 7'd1;
                  else v[0] = 1'b0;
               end
               if (v[1] && !last_start[1]) begin
                  if (credits >= 7'd2) credits = credits - 7'd2;
                  else v[1] = 1'b0;
               end
               last_start = v;
               r = {4'h0, v};
            end
            OFS_TENS:  r = {1'b0, credits / 7'd10};
            OFS_UNITS: r = {1'b0, credits % 7'd10};
            OFS_P4_HI: r = {4'h0, a.p4[7:4]};
            OFS_P5_HI: r = {4'h0, a.p5[7:4]};
            OFS_P1_HI: r = {4'h0, a.p1[7:4]};
            OFS_P0_LO: r = {4'h0, a.p0[3:0]};
            OFS_P0_HI: r = {4'h0, a.p0[7:4]};
            OFS_P1_LO: r = {4'h0, a.p1[3:0]};
            OFS_P4_LO: r = {4'h0, a.p4[3:0]};
            OFS_P5_LO: r = {4'h0, a.p5[3:0]};
            OFS_P2_LO: r = {4'h0, a.p2[3:0]};
            default: r = io_ram_copy[a.ofs];
         endcase
      end else begin
         r = io_ram_copy[a.ofs];
      end
      return r;
   endfunction

   function automatic access_row_type random_access();
      access_row_type a;
      int unsigned pick;
      a.kind  = ACC_READ;
      a.ofs   = 6'($urandom);
      a.wdata = 8'($urandom);
      a.p0    = 8'($urandom);
      a.p1    = 8'($urandom);
      a.p2    = 8'($urandom);
      a.p3    = 8'($urandom);
      a.p4    = 8'($urandom);
      a.p5    = 8'($urandom);
      a.fixed = 1'b0;
      a.want  = 8'h00;
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
         a.kind = ACC_WRITE;
         a.ofs  = MODE_ENTRY;
         pick = $urandom_range(0, 19);
         if (pick < 12) a.wdata = MODE_PORTS;
         else if (pick < 15) a.wdata = MODE_TEST;
         else if (pick < 17) a.wdata = 8'h00;
      end else if (pick < 20) begin
         a.kind = ACC_WRITE;
      end else if (pick < 50) begin
         // favour coin A's richest coinage so the credit count climbs to its limit
         a.ofs = OFS_COIN;
         if ($urandom_range(0, 1) == 0) a.p1[7:5] = 3'd6;
      end else if (pick < 65) begin
         a.ofs = OFS_START;
      end else if (pick < 75) begin
         a.ofs = ($urandom_range(0, 1) == 0) ? OFS_TENS : OFS_UNITS;
      end else if (pick < 90) begin
         a.ofs = MAPPED[$urandom_range(0, 12)];
      end
      return a;
   endfunction

   task automatic report_mismatch(string what, int idx, logic [7:0] got, logic [7:0] want);
      $display("mismatch: %s, word %0d, read_data %02h, expected %02h",
               what, idx, got, want);
      mismatches++;
   endtask

   initial begin : req_side
      access_row_type row;
      logic [7:0]     due;
      int             gap;
      bit             calm_tx;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_type       = ACC_WRITE;
      req_offset     = 6'd0;
      req_write_data = 8'h00;
      req_port0      = 8'h00;
      req_port1      = 8'h00;
      req_port2      = 8'h00;
      req_port3      = 8'h00;
      req_port4      = 8'h00;
      req_port5      = 8'h00;
      rsp_ready      = 1'b0;
      for (int k = 0; k < 64; k++) io_ram_copy[k] = 8'h00;
      credits    = 7'd0;
      coin_a_cnt = 2'd0;
      coin_b_cnt = 2'd0;
      last_coin  = 4'h0;
      last_start = 4'h0;
      calm_tx    = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < N_DIRECTED + N_RANDOM; i++) begin
         if (i % 50 == 0) calm_tx = ($urandom_range(0, 3) == 0);
         row = (i < N_DIRECTED) ? DIRECTED[i] : random_access();
         gap = calm_tx ? 0 : $urandom_range(0, 11);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_valid      <= 1'b1;
         req_type       <= row.kind;
         req_offset     <= row.ofs;
         req_write_data <= row.wdata;
         req_port0      <= row.p0;
         req_port1      <= row.p1;
         req_port2      <= row.p2;
         req_port3      <= row.p3;
         req_port4      <= row.p4;
         req_port5      <= row.p5;
         do @(posedge clock); while (!req_ready);
         due = bus_access_result(row);
         read_bytes_due.push_back('{idx: i, val: (row.fixed ? row.want : due)});
      end
      req_valid <= 1'b0;
      while (read_bytes_due.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (mismatches == 0) begin
         $display("[coin_credit_custom_io] OK");
      end else begin
         $display("[coin_credit_custom_io] ERROR");
      end
      $finish;
   end

   initial begin : rsp_side
      due_byte_type e;
      int           stall;
      bit           calm_rx;
      calm_rx = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_count % 40 == 0) calm_rx = ($urandom_range(0, 3) == 0);
         stall = calm_rx ? 0 : $urandom_range(0, 11);
         if (hold_off && stall == 0) stall = 1;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
            while (hold_off) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         if (read_bytes_due.size() == 0) begin
            report_mismatch("word with none due", -1, rsp_read_data, 8'h00);
         end else begin
            e = read_bytes_due.pop_front();
            if (rsp_read_data !== e.val) report_mismatch("read_data", e.idx, rsp_read_data, e.val);
         end
         rsp_count++;
      end
   end

   // hold the result side off long enough for the block to fill and stall
   initial begin : long_hold
      while (rsp_count < 150) @(posedge clock);
      hold_off = 1'b1;
      repeat (80) @(posedge clock);
      hold_off = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("[coin_credit_custom_io] ERROR");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

endmodule

/* sim.f */
sv/ccio_pkg.sv
sv/ccio_ram.sv
sv/ccio_credit.sv
sv/coin_credit_custom_io.sv
sv/ccio_checker.sv
sim/tb_top.sv
